// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

// ----- hw/rtl/dmwtc_pkg.sv -----
// Shared types and constants for the direct-mapped write-through cache.
package dmwtc_pkg;

	// Field widths of the request and result transactions.
	localparam int ADDR_W     = 10;
	localparam int IO_DATA_W  = 32;
	localparam int TAG_W      = 9;
	localparam int LINE_OUT_W = 7;
	localparam int WORD_OUT_W = 8;
	localparam int S_TDATA_W  = 48;
	localparam int M_TDATA_W  = 56;

	// Configuration port.
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_W-1:0] CACHE_LOG2_RST = 4'd8;
	localparam logic [CFG_W-1:0] BLOCK_LOG2_RST = 4'd2;
	localparam int LOG2_MIN = 1;
	localparam int LOG2_MAX = 8;

	// Default sizes handed to the top level.
	localparam int MEM_WORDS_DEF   = 1024;
	localparam int CACHE_WORDS_DEF = 256;
	localparam int DATA_BITS_DEF   = 32;

	localparam logic REQ_WRITE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CACHE_LOG2 = 1'b0,
		CFG_BLOCK_LOG2 = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_REDUCE,
		ST_SPLIT,
		ST_COMPARE,
		ST_FILL,
		ST_ACCESS,
		ST_RESULT
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic init;
		logic load;
		logic reduce;
		logic split;
		logic compare;
		logic fill;
		logic access;
		logic result;
	} dp_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic init_done;
		logic hit;
		logic fill_done;
		logic out_free;
	} dp_status_t;

endpackage

// ----- hw/rtl/dmwtc_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module dmwtc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/dmwtc_ctrl.sv -----
// Controller state machine for the cache: sequences init, lookup, fill and result.
module dmwtc_ctrl import dmwtc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t st,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd.init = 1'b1;
				if (st.init_done) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid) begin
					state_n = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				cmd.reduce = 1'b1;
				state_n    = ST_SPLIT;
			end
			ST_SPLIT: begin
				cmd.split = 1'b1;
				state_n   = ST_COMPARE;
			end
			ST_COMPARE: begin
				cmd.compare = 1'b1;
				state_n     = st.hit ? ST_RESULT : ST_FILL;
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				if (st.fill_done) begin
					state_n = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				cmd.access = 1'b1;
				state_n    = ST_RESULT;
			end
			ST_RESULT: begin
				cmd.result = 1'b1;
				if (st.out_free) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_INIT;
			end
		endcase
	end

endmodule

// ----- hw/rtl/dmwtc_dp.sv -----
// Cache datapath: geometry, address split, tag and data stores, memory and output register.
module dmwtc_dp import dmwtc_pkg::*; #(
	parameter int MEM_WORDS   = MEM_WORDS_DEF,
	parameter int CACHE_WORDS = CACHE_WORDS_DEF,
	parameter int DATA_BITS   = DATA_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_W-1:0]      cfg_wdata,
	input  logic                  req_type,
	input  logic [ADDR_W-1:0]     address,
	input  logic [IO_DATA_W-1:0]  write_data,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic                  hit,
	output logic [IO_DATA_W-1:0]  data_value,
	output logic [TAG_W-1:0]      tag_value,
	output logic [LINE_OUT_W-1:0] line_index,
	output logic [WORD_OUT_W-1:0] word_offset,
	input  dp_cmd_t               cmd,
	output dp_status_t            st
);

	localparam int MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam int MEM_CW    = $clog2(MEM_WORDS + 1);
	localparam int CW_LOG    = $clog2(CACHE_WORDS + 1) - 1;
	localparam int CS_MAX    = (CW_LOG < LOG2_MAX) ? CW_LOG : LOG2_MAX;
	localparam int LINE_W    = (CS_MAX > 1) ? CS_MAX - 1 : 1;
	localparam int LINES     = 2 ** LINE_W;
	localparam int DIDX_W    = CS_MAX;
	localparam int CNT_W     = CS_MAX + 1;
	localparam int RED_SHIFT = 2 * ADDR_W;
	localparam int RECIP     = (2 ** RED_SHIFT + MEM_WORDS - 1) / MEM_WORDS;
	localparam int RECIP_W   = $clog2(RECIP + 1);
	localparam int PROD_W    = ADDR_W + RECIP_W;
	localparam int RW        = ADDR_W + MEM_CW;

	// Saturate a log2 size setting to the supported range.
	function automatic logic [CFG_W-1:0] clamp_log2(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] r;
		r = v;
		if (v < CFG_W'(LOG2_MIN)) begin
			r = CFG_W'(LOG2_MIN);
		end else if (v > CFG_W'(LOG2_MAX)) begin
			r = CFG_W'(LOG2_MAX);
		end
		return r;
	endfunction

	// Configuration and control state.
	logic [CFG_W-1:0]  cfg_cache_q, cfg_block_q;
	logic [LINES-1:0]  line_valid_q;
	logic [MEM_AW-1:0] init_cnt_q;
	logic [CNT_W-1:0]  fill_cnt_q;
	logic              fill_wr_s1;
	logic              out_valid_q;

	// Request payload.
	logic                 req_q;
	logic [ADDR_W-1:0]    raw_addr_q, quot_q, addr_q, base_q;
	logic [DATA_BITS-1:0] wdata_q;
	logic [TAG_W-1:0]     tag_q;
	logic [LINE_W-1:0]    line_q;
	logic [DIDX_W-1:0]    didx_q, word_q, fill_idx_s1;
	logic [MEM_AW-1:0]    mem_ptr_q;
	logic                 hit_q;

	// Output register payload.
	logic                  out_hit_q;
	logic [IO_DATA_W-1:0]  out_data_q;
	logic [TAG_W-1:0]      out_tag_q;
	logic [LINE_OUT_W-1:0] out_line_q;
	logic [WORD_OUT_W-1:0] out_word_q;

	// Combinational terms.
	logic [CFG_W-1:0]     cs_clamp, cs_eff, bs_clamp, bs_eff;
	logic [ADDR_W-1:0]    mask_cs, mask_bs, didx_full, base_c;
	logic [TAG_W-1:0]     tag_c;
	logic [LINE_W-1:0]    line_c;
	logic [DIDX_W-1:0]    didx_c, word_c, lbase, fill_idx;
	logic [CNT_W-1:0]     bwords;
	logic [PROD_W-1:0]    prod;
	logic [RW-1:0]        qm, rem, rem_c;
	logic [MEM_CW-1:0]    init_diff;
	logic [DATA_BITS-1:0] init_val, mem_rd, data_rd;
	logic [TAG_W-1:0]     tag_rd;
	logic                 hit_c, miss_c, acc_wr, fill_issue, out_free;

	always_comb begin
		cs_clamp  = clamp_log2(cfg_cache_q);
		cs_eff    = (cs_clamp > CFG_W'(CS_MAX)) ? CFG_W'(CS_MAX) : cs_clamp;
		bs_clamp  = clamp_log2(cfg_block_q);
		bs_eff    = (bs_clamp > cs_eff) ? cs_eff : bs_clamp;
		mask_cs   = ~({ADDR_W{1'b1}} << cs_eff);
		mask_bs   = ~({ADDR_W{1'b1}} << bs_eff);
		tag_c     = TAG_W'(addr_q >> cs_eff);
		didx_full = addr_q & mask_cs;
		didx_c    = DIDX_W'(didx_full);
		line_c    = LINE_W'(didx_full >> bs_eff);
		word_c    = DIDX_W'(addr_q & mask_bs);
		base_c    = addr_q & ~mask_bs;
		bwords    = CNT_W'(1) << bs_eff;
		lbase     = didx_q & ~DIDX_W'(mask_bs);
		fill_idx  = lbase | DIDX_W'(fill_cnt_q);
	end

	// Address reduction modulo the memory size: reciprocal multiply at accept,
	// then multiply back, subtract and correct once.
	assign prod  = PROD_W'(address) * PROD_W'(RECIP);
	assign qm    = RW'(quot_q) * RW'(MEM_WORDS);
	assign rem   = RW'(raw_addr_q) - qm;
	assign rem_c = (rem >= RW'(MEM_WORDS)) ? rem - RW'(MEM_WORDS) : rem;

	// Reset image of main memory: word i holds MEM_WORDS minus i.
	assign init_diff = MEM_CW'(MEM_WORDS) - MEM_CW'(init_cnt_q);
	assign init_val  = DATA_BITS'(init_diff);

	assign hit_c      = line_valid_q[line_q] && (tag_rd == tag_q);
	assign miss_c     = cmd.compare && !hit_c;
	assign acc_wr     = (req_q == REQ_WRITE) && ((cmd.compare && hit_c) || cmd.access);
	assign fill_issue = cmd.fill && (fill_cnt_q != bwords);
	assign out_free   = !out_valid_q || out_ready;

	assign st.init_done = (init_cnt_q == MEM_AW'(MEM_WORDS - 1));
	assign st.hit       = hit_c;
	assign st.fill_done = (fill_cnt_q == bwords) && !fill_wr_s1;
	assign st.out_free  = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_cache_q  <= CACHE_LOG2_RST;
			cfg_block_q  <= BLOCK_LOG2_RST;
			line_valid_q <= '0;
			init_cnt_q   <= '0;
			fill_cnt_q   <= '0;
			fill_wr_s1   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_CACHE_LOG2: cfg_cache_q <= cfg_wdata;
					CFG_BLOCK_LOG2: cfg_block_q <= cfg_wdata;
					default: ;
				endcase
				// A new geometry makes every filled line meaningless.
				line_valid_q <= '0;
			end else if (miss_c) begin
				line_valid_q[line_q] <= 1'b1;
			end
			if (cmd.init) begin
				init_cnt_q <= init_cnt_q + MEM_AW'(1);
			end
			if (miss_c) begin
				fill_cnt_q <= '0;
			end else if (fill_issue) begin
				fill_cnt_q <= fill_cnt_q + CNT_W'(1);
			end
			fill_wr_s1 <= fill_issue;
			if (cmd.result && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q      <= req_type;
			raw_addr_q <= address;
			wdata_q    <= DATA_BITS'($signed(write_data));
			quot_q     <= ADDR_W'(prod >> RED_SHIFT);
		end
		if (cmd.reduce) begin
			addr_q <= ADDR_W'(rem_c);
		end
		if (cmd.split) begin
			tag_q  <= tag_c;
			line_q <= line_c;
			didx_q <= didx_c;
			word_q <= word_c;
			base_q <= base_c;
		end
		if (cmd.compare) begin
			hit_q     <= hit_c;
			mem_ptr_q <= MEM_AW'(base_q);
		end else if (fill_issue) begin
			mem_ptr_q <= (mem_ptr_q == MEM_AW'(MEM_WORDS - 1)) ? '0 : mem_ptr_q + MEM_AW'(1);
		end
		fill_idx_s1 <= fill_idx;
		if (cmd.result && out_free) begin
			out_hit_q  <= hit_q;
			out_data_q <= (req_q == REQ_WRITE) ? IO_DATA_W'(wdata_q) : IO_DATA_W'(data_rd);
			out_tag_q  <= tag_q;
			out_line_q <= LINE_OUT_W'(line_q);
			out_word_q <= WORD_OUT_W'(word_q);
		end
	end

	dmwtc_ram #(
		.WIDTH (DATA_BITS),
		.DEPTH (MEM_WORDS)
	) u_main_mem (
		.clk   (clk),
		.we    (cmd.init || acc_wr),
		.waddr (cmd.init ? init_cnt_q : MEM_AW'(addr_q)),
		.wdata (cmd.init ? init_val : wdata_q),
		.raddr (mem_ptr_q),
		.rdata (mem_rd)
	);

	dmwtc_ram #(
		.WIDTH (TAG_W),
		.DEPTH (LINES)
	) u_tag_ram (
		.clk   (clk),
		.we    (miss_c),
		.waddr (line_q),
		.wdata (tag_q),
		.raddr (line_c),
		.rdata (tag_rd)
	);

	dmwtc_ram #(
		.WIDTH (DATA_BITS),
		.DEPTH (2 ** CS_MAX)
	) u_data_ram (
		.clk   (clk),
		.we    (fill_wr_s1 || acc_wr),
		.waddr (fill_wr_s1 ? fill_idx_s1 : didx_q),
		.wdata (fill_wr_s1 ? mem_rd : wdata_q),
		.raddr (didx_q),
		.rdata (data_rd)
	);

	assign out_valid   = out_valid_q;
	assign hit         = out_hit_q;
	assign data_value  = out_data_q;
	assign tag_value   = out_tag_q;
	assign line_index  = out_line_q;
	assign word_offset = out_word_q;

endmodule

// ----- hw/rtl/direct_mapped_write_through_cache.sv -----
// Top level of the direct-mapped, write-allocate, write-through cache.
//
// Channel  | Dir | Contents
// s_axis   | in  | tuser: req_type; tdata: address, write_data
// m_axis   | out | tuser: hit; tdata: data_value, tag_value, line_index, word_offset
// cfg      | in  | cfg_we, cfg_addr (register index), cfg_wdata
//
// A new request is taken only after the previous one has loaded its result. A miss
// adds a line fill of 2^b words, where b is block_size_log2 after saturation to 1..8
// and clamping to the cache size; the fill moves one word per cycle through the main
// memory read port into the line data store.
// After reset the block sweeps main memory once to load its initial image, with
// s_axis_tready low throughout the sweep; config writes are taken.
// A result waits in the output register while the next request is processed;
// only the result hand-off stalls on m_axis_tready.
`include "assert_macros.svh"

module direct_mapped_write_through_cache import dmwtc_pkg::*; #(
	parameter int MEM_WORDS   = MEM_WORDS_DEF,
	parameter int CACHE_WORDS = CACHE_WORDS_DEF,
	parameter int DATA_BITS   = DATA_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port.
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata,
	// Request stream.
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // address[9:0], write_data[41:10], zero pad
	input  logic                 s_axis_tuser,  // req_type
	// Result stream.
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,  // data_value[31:0], tag_value[40:32],
	                                            // line_index[47:41], word_offset[55:48]
	output logic                 m_axis_tuser   // hit
);

	dp_cmd_t    cmd;
	dp_status_t st;

	logic                  hit;
	logic [IO_DATA_W-1:0]  data_value;
	logic [TAG_W-1:0]      tag_value;
	logic [LINE_OUT_W-1:0] line_index;
	logic [WORD_OUT_W-1:0] word_offset;

	// The controller walks each transaction through its steps; it never
	// touches payload, only commands the datapath and reads back status.
	dmwtc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// The datapath holds the size registers, valid bits, tag and data
	// stores, main memory and the output register.
	dmwtc_dp #(
		.MEM_WORDS   (MEM_WORDS),
		.CACHE_WORDS (CACHE_WORDS),
		.DATA_BITS   (DATA_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.req_type    (s_axis_tuser),
		.address     (s_axis_tdata[ADDR_W-1:0]),
		.write_data  (s_axis_tdata[ADDR_W+IO_DATA_W-1:ADDR_W]),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.hit         (hit),
		.data_value  (data_value),
		.tag_value   (tag_value),
		.line_index  (line_index),
		.word_offset (word_offset),
		.cmd         (cmd),
		.st          (st)
	);

	// Result fields are packed from the lowest bit up with no gaps.
	assign m_axis_tdata = {word_offset, line_index, tag_value, data_value};
	assign m_axis_tuser = hit;

	// Every accepted request moves on to the address reduction step.
	`ASSERT_ALWAYS(a_accept_starts_reduce, clk, arst_n,
		s_axis_tvalid && s_axis_tready |=> cmd.reduce,
		"accepted request did not enter address reduction")

	// A result only appears after the controller reached its result step.
	`ASSERT_ALWAYS(a_result_from_load, clk, arst_n,
		$rose(m_axis_tvalid) |-> $past(cmd.result),
		"result became valid without a result load")

	// No request may be taken while the memory image is still being loaded.
	`ASSERT_NEVER(a_no_accept_in_init, clk, arst_n,
		cmd.init && s_axis_tready,
		"request port ready during memory initialization")

endmodule
